### design/igbc_pkg.sv
// Package for the gyro bias collector: word types, codes and fixed widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package igbc_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int TEMP_W         = 16;
  localparam int OUT_CNT_W      = 20;
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int COUNT_BITS_DEF = 20;
  localparam int NUM_AXES       = 3;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_BOUND  = -16'sd5120;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_BOUND = 16'sd15360;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_ACCEL   = 3'd1;
  localparam logic [2:0] ACT_GYRO    = 3'd2;
  localparam logic [2:0] ACT_TICK    = 3'd3;
  localparam logic [2:0] ACT_TIMEOUT = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MOTION   = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT  = 2'd2;
  localparam logic [1:0] STAT_TOO_FEW  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYR_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT  = 3'd5;

  typedef struct packed {
    logic [2:0]                 action;
    logic signed [SAMPLE_W-1:0] axis_x;
    logic signed [SAMPLE_W-1:0] axis_y;
    logic signed [SAMPLE_W-1:0] axis_z;
    logic signed [TEMP_W-1:0]   temperature;
    logic                       temp_present;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [SAMPLE_W-1:0] bias_x;
    logic signed [SAMPLE_W-1:0] bias_y;
    logic signed [SAMPLE_W-1:0] bias_z;
    logic signed [TEMP_W-1:0]   mean_temp;
    logic                       mean_temp_valid;
    logic [14:0]                temp_span;
    logic [OUT_CNT_W-1:0]       samples_taken;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic seed_acc;
    logic upd_acc;
    logic seed_gyr;
    logic upd_gyr;
    logic accum;
  } lane_ctrl_t;

  typedef struct packed {
    logic acc_over;
    logic gyr_over;
  } lane_flags_t;

endpackage
`default_nettype wire

### design/igbc_axis_lane.sv
// One axis lane: accel and gyro low/high trackers, span check, gyro sum.
// Depends on igbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module igbc_axis_lane import igbc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire lane_ctrl_t                          ctrl,
  input  wire logic signed [SAMPLE_W-1:0]          sample,
  input  wire logic [CFG_W-1:0]                    acc_limit,
  input  wire logic [CFG_W-1:0]                    gyr_limit,
  output lane_flags_t                              flags,
  output logic signed [SAMPLE_W+COUNT_BITS-1:0]    total
);

  localparam int TOT_W = SAMPLE_W + COUNT_BITS;

  logic signed [SAMPLE_W-1:0] acc_lo, acc_hi, gyr_lo, gyr_hi;
  logic signed [SAMPLE_W-1:0] acc_lo_next, acc_hi_next, gyr_lo_next, gyr_hi_next;
  logic [SAMPLE_W:0]          acc_span, gyr_span;

  always_comb begin
    acc_lo_next = (sample < acc_lo) ? sample : acc_lo;
    acc_hi_next = (sample > acc_hi) ? sample : acc_hi;
    gyr_lo_next = (sample < gyr_lo) ? sample : gyr_lo;
    gyr_hi_next = (sample > gyr_hi) ? sample : gyr_hi;
    acc_span = (SAMPLE_W+1)'(acc_hi_next) - (SAMPLE_W+1)'(acc_lo_next);
    gyr_span = (SAMPLE_W+1)'(gyr_hi_next) - (SAMPLE_W+1)'(gyr_lo_next);
    flags.acc_over = acc_span > (SAMPLE_W+1)'(acc_limit);
    flags.gyr_over = gyr_span > (SAMPLE_W+1)'(gyr_limit);
  end

  always_ff @(posedge clk) begin
    if (ctrl.seed_acc) begin
      acc_lo <= sample;
      acc_hi <= sample;
    end else if (ctrl.upd_acc) begin
      acc_lo <= acc_lo_next;
      acc_hi <= acc_hi_next;
    end
    if (ctrl.seed_gyr) begin
      gyr_lo <= sample;
      gyr_hi <= sample;
    end else if (ctrl.upd_gyr) begin
      gyr_lo <= gyr_lo_next;
      gyr_hi <= gyr_hi_next;
    end
    if (ctrl.clear) begin
      total <= '0;
    end else if (ctrl.accum) begin
      total <= total + TOT_W'(sample);
    end
  end

endmodule
`default_nettype wire

### design/igbc_divider.sv
// Serial signed divider, one quotient bit a cycle, truncating toward zero.
// Depends on igbc_pkg for default widths only.
`timescale 1ns / 1ps
`default_nettype none
module igbc_divider import igbc_pkg::*; #(
  parameter int DW = SAMPLE_W + COUNT_BITS_DEF,
  parameter int CW = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic [CW-1:0]        divisor,
  output logic                      busy,
  output logic signed [DW-1:0]      quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    q;
  logic [CW:0]      rem;
  logic [CW-1:0]    d;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [CW:0]      rem_sh;
  logic [DW-1:0]    mag;

  always_comb begin
    rem_sh   = {rem[CW-1:0], q[DW-1]};
    mag      = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    quotient = neg ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      q    <= mag;
      rem  <= '0;
      d    <= divisor;
      neg  <= dividend[DW-1];
      cnt  <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
        q   <= {q[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[DW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DW - 1)) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/imu_gyro_bias_collector_top.sv
// Top level of the gyro bias collector: run control, temperature tracking,
// three axis lanes, four dividers and the result register. Needs igbc_pkg.
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid / in_stall     | in_word  (in_word_t)
//   out     | out | out_valid / out_stall   | out_word (out_word_t)
//   cfg     | in  | cfg_wr_en               | cfg_index, cfg_data
//
// A finish with status ok runs the dividers, then loads the result register,
// with the input stalled meanwhile.
// While a result waits and a new run is armed, the input stalls.
// Reset is synchronous; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none
module imu_gyro_bias_collector_top import igbc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int TOT_W  = SAMPLE_W + COUNT_BITS;
  localparam int TTOT_W = TEMP_W + COUNT_BITS;

  typedef enum logic {ST_OPEN, ST_DIV} state_t;

  state_t state;

  logic [15:0]            cfg_max_time, cfg_min_time;
  logic [OUT_CNT_W-1:0]   cfg_min_samples;
  logic [CFG_W-1:0]       cfg_acc_limit, cfg_gyr_limit;
  logic [14:0]            cfg_span_limit;

  logic                     running, accel_seeded, gyro_seeded;
  logic signed [TTOT_W-1:0] temp_total;
  logic [COUNT_BITS-1:0]    temp_count, sample_count;
  logic                     temp_any, temp_reached;
  logic signed [TEMP_W-1:0] temp_low, temp_high;
  logic [15:0]              elapsed_ms;

  logic                     accept, is_sample, finish, sample_go, motion, room, tv;
  logic                     too_few, div_start, div_idle;
  logic signed [TEMP_W-1:0] t, tlo_next, thi_next;
  logic [TEMP_W:0]          tspan_next;
  lane_ctrl_t               ctrl;
  lane_flags_t              flags [NUM_AXES];
  logic [NUM_AXES-1:0]      acc_over, gyr_over;
  logic signed [SAMPLE_W-1:0] samp [NUM_AXES];
  logic signed [TOT_W-1:0]  totals [NUM_AXES];
  logic signed [TOT_W-1:0]  quots [NUM_AXES];
  logic signed [TTOT_W-1:0] tquot;
  logic [NUM_AXES:0]        busy;
  logic [OUT_CNT_W-1:0]     cnt_out;

  assign in_stall = (state == ST_DIV) || (out_valid && running);
  assign accept   = in_valid && !in_stall;
  assign samp[0]  = in_word.axis_x;
  assign samp[1]  = in_word.axis_y;
  assign samp[2]  = in_word.axis_z;
  assign cnt_out  = OUT_CNT_W'(sample_count);

  always_comb begin
    t          = in_word.temperature;
    tv         = in_word.temp_present && (t > TEMP_LOW_BOUND) && (t < TEMP_HIGH_BOUND);
    is_sample  = (in_word.action == ACT_ACCEL) || (in_word.action == ACT_GYRO);
    finish     = (elapsed_ms >= cfg_max_time) ||
                 ((elapsed_ms >= cfg_min_time) && temp_reached);
    sample_go  = accept && running && is_sample && !finish;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc_over[i] = flags[i].acc_over;
      gyr_over[i] = flags[i].gyr_over;
    end
    motion     = (in_word.action == ACT_ACCEL) ? (|acc_over) : (|gyr_over);
    room       = sample_count != '1;
    too_few    = (sample_count == '0) ||
                 (32'(sample_count) < 32'(cfg_min_samples));
    div_start  = accept && running && is_sample && finish && !too_few;
    div_idle   = !(|busy);
    ctrl.clear    = accept && (in_word.action == ACT_START);
    ctrl.seed_acc = sample_go && (in_word.action == ACT_ACCEL) && !accel_seeded;
    ctrl.upd_acc  = sample_go && (in_word.action == ACT_ACCEL) && accel_seeded;
    ctrl.seed_gyr = sample_go && (in_word.action == ACT_GYRO) && !gyro_seeded;
    ctrl.upd_gyr  = sample_go && (in_word.action == ACT_GYRO) && gyro_seeded;
    ctrl.accum    = ctrl.upd_gyr && !motion && room;
    tlo_next   = (!temp_any || t < temp_low) ? t : temp_low;
    thi_next   = (!temp_any || t > temp_high) ? t : temp_high;
    tspan_next = (TEMP_W+1)'(thi_next) - (TEMP_W+1)'(tlo_next);
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    igbc_axis_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .sample    (samp[g]),
      .acc_limit (cfg_acc_limit),
      .gyr_limit (cfg_gyr_limit),
      .flags     (flags[g]),
      .total     (totals[g])
    );
    igbc_divider #(.DW(TOT_W), .CW(COUNT_BITS)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (totals[g]),
      .divisor  (sample_count),
      .busy     (busy[g]),
      .quotient (quots[g])
    );
  end

  igbc_divider #(.DW(TTOT_W), .CW(COUNT_BITS)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (temp_total),
    .divisor  (temp_count),
    .busy     (busy[NUM_AXES]),
    .quotient (tquot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max_time    <= 16'd10000;
      cfg_min_time    <= 16'd5000;
      cfg_min_samples <= '0;
      cfg_acc_limit   <= '0;
      cfg_gyr_limit   <= '0;
      cfg_span_limit  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_TIME:    cfg_max_time    <= cfg_data[15:0];
        CFG_MIN_TIME:    cfg_min_time    <= cfg_data[15:0];
        CFG_MIN_SAMPLES: cfg_min_samples <= cfg_data[OUT_CNT_W-1:0];
        CFG_ACC_LIMIT:   cfg_acc_limit   <= cfg_data;
        CFG_GYR_LIMIT:   cfg_gyr_limit   <= cfg_data;
        CFG_SPAN_LIMIT:  cfg_span_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_OPEN;
      running      <= 1'b0;
      accel_seeded <= 1'b0;
      gyro_seeded  <= 1'b0;
      temp_total   <= '0;
      temp_count   <= '0;
      temp_any     <= 1'b0;
      temp_reached <= 1'b0;
      elapsed_ms   <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_OPEN: begin
          if (accept && in_word.action == ACT_START) begin
            running      <= 1'b1;
            accel_seeded <= 1'b0;
            gyro_seeded  <= 1'b0;
            temp_total   <= '0;
            temp_count   <= '0;
            temp_any     <= tv;
            temp_low     <= t;
            temp_high    <= t;
            temp_reached <= 1'b0;
            elapsed_ms   <= '0;
            sample_count <= '0;
          end else if (accept && running) begin
            case (in_word.action)
              ACT_TICK: begin
                if (elapsed_ms != ELAPSED_MAX) elapsed_ms <= elapsed_ms + 1'b1;
              end
              ACT_TIMEOUT: begin
                running   <= 1'b0;
                out_valid <= 1'b1;
                out_word  <= '{status: STAT_TIMEOUT, samples_taken: cnt_out, default: '0};
              end
              ACT_ACCEL, ACT_GYRO: begin
                if (finish) begin
                  running <= 1'b0;
                  if (too_few) begin
                    out_valid <= 1'b1;
                    out_word  <= '{status: STAT_TOO_FEW, samples_taken: cnt_out,
                                   default: '0};
                  end else begin
                    state <= ST_DIV;
                  end
                end else if (ctrl.seed_acc) begin
                  accel_seeded <= 1'b1;
                end else if (ctrl.seed_gyr) begin
                  gyro_seeded <= 1'b1;
                end else if (motion) begin
                  running   <= 1'b0;
                  out_valid <= 1'b1;
                  out_word  <= '{status: STAT_MOTION, samples_taken: cnt_out, default: '0};
                end else if (in_word.action == ACT_GYRO) begin
                  if (room) sample_count <= sample_count + 1'b1;
                  if (tv) begin
                    if (room) begin
                      temp_total <= temp_total + TTOT_W'(t);
                      temp_count <= temp_count + 1'b1;
                    end
                    temp_any  <= 1'b1;
                    temp_low  <= tlo_next;
                    temp_high <= thi_next;
                    if (tspan_next >= (TEMP_W+1)'(cfg_span_limit)) temp_reached <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_idle) begin
            state     <= ST_OPEN;
            out_valid <= 1'b1;
            out_word.status          <= STAT_OK;
            out_word.bias_x          <= quots[0][SAMPLE_W-1:0];
            out_word.bias_y          <= quots[1][SAMPLE_W-1:0];
            out_word.bias_z          <= quots[2][SAMPLE_W-1:0];
            out_word.mean_temp       <= (temp_count != '0) ? tquot[TEMP_W-1:0] : '0;
            out_word.mean_temp_valid <= temp_count != '0;
            out_word.temp_span       <= temp_any ?
                                        15'(temp_high - temp_low) : '0;
            out_word.samples_taken   <= cnt_out;
          end
        end
        default: state <= ST_OPEN;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/igbc_checker.sv
// Port-level checks of the gyro bias collector, bound to the top level.
// Depends on igbc_pkg and imu_gyro_bias_collector_top.
`timescale 1ns / 1ps
`default_nettype none
module igbc_checker import igbc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != STAT_OK |->
      out_word.bias_x == '0 && out_word.bias_y == '0 && out_word.bias_z == '0 &&
      !out_word.mean_temp_valid && out_word.temp_span == '0)
    else $error("error result carries data");

  a_ok_has_samples: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == STAT_OK |-> out_word.samples_taken != '0)
    else $error("ok result with no samples");

  a_mean_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.mean_temp_valid |-> out_word.mean_temp == '0)
    else $error("mean temperature without valid flag");

endmodule

bind imu_gyro_bias_collector_top igbc_checker u_igbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

### tb/imu_gyro_bias_collector_top_test.sv
// Self-checking bench for the gyro bias collector top level: directed runs,
// then random calibration runs under varied registers, idling and stalls.
// Depends on igbc_pkg and imu_gyro_bias_collector_top.
`timescale 1ns / 1ps
module imu_gyro_bias_collector_top_test;
  import igbc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 80;

  class bias_scoreboard;
    logic [15:0] max_t, min_t;
    logic [19:0] min_s;
    logic [30:0] acc_lim, gyr_lim;
    logic [14:0] span_lim;
    bit running, seeded[2], t_any, reached;
    longint lo[2][3], hi[2][3], g_tot[3], t_tot, t_cnt, s_cnt;
    int t_lo, t_hi, elapsed;
    out_word_t expected_q[$];

    function new();
      max_t = 16'd10000;
      min_t = 16'd5000;
      min_s = '0;
      acc_lim = '0;
      gyr_lim = '0;
      span_lim = '0;
      running = 0;
      clear_run();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MAX_TIME:    max_t = val[15:0];
        CFG_MIN_TIME:    min_t = val[15:0];
        CFG_MIN_SAMPLES: min_s = val[19:0];
        CFG_ACC_LIMIT:   acc_lim = val[30:0];
        CFG_GYR_LIMIT:   gyr_lim = val[30:0];
        CFG_SPAN_LIMIT:  span_lim = val[14:0];
        default: ;
      endcase
    endfunction

    function void clear_run();
      seeded[0] = 0;
      seeded[1] = 0;
      for (int j = 0; j < 3; j++) begin
        g_tot[j] = 0;
        lo[0][j] = 0; hi[0][j] = 0; lo[1][j] = 0; hi[1][j] = 0;
      end
      t_tot = 0;
      t_cnt = 0;
      t_any = 0;
      t_lo = 0;
      t_hi = 0;
      reached = 0;
      elapsed = 0;
      s_cnt = 0;
    endfunction

    function bit temp_ok(in_word_t w);
      return w.temp_present && (w.temperature > TEMP_LOW_BOUND) &&
             (w.temperature < TEMP_HIGH_BOUND);
    endfunction

    function void finish(logic [1:0] st);
      out_word_t e;
      e = '0;
      e.status = st;
      e.samples_taken = s_cnt[19:0];
      if (st == STAT_OK) begin
        e.bias_x = 32'(g_tot[0] / s_cnt);
        e.bias_y = 32'(g_tot[1] / s_cnt);
        e.bias_z = 32'(g_tot[2] / s_cnt);
        if (t_cnt > 0) begin
          e.mean_temp = 16'(t_tot / t_cnt);
          e.mean_temp_valid = 1'b1;
        end
        if (t_any) e.temp_span = 15'(t_hi - t_lo);
      end
      running = 0;
      expected_q.push_back(e);
    endfunction

    function bit track(int k, longint v[3], longint lim);
      for (int j = 0; j < 3; j++) begin
        if (v[j] < lo[k][j]) lo[k][j] = v[j];
        if (v[j] > hi[k][j]) hi[k][j] = v[j];
        if (hi[k][j] - lo[k][j] > lim) return 1;
      end
      return 0;
    endfunction

    function void note_input(in_word_t w);
      longint v[3];
      int k, t;
      bit room;
      t = w.temperature;
      if (w.action == ACT_START) begin
        clear_run();
        running = 1;
        if (temp_ok(w)) begin
          t_any = 1; t_lo = t; t_hi = t;
        end
        return;
      end
      if (!running || w.action > ACT_TIMEOUT) return;
      if (w.action == ACT_TICK) begin
        if (elapsed < 65535) elapsed++;
        return;
      end
      if (w.action == ACT_TIMEOUT) begin
        finish(STAT_TIMEOUT);
        return;
      end
      if (elapsed >= max_t || (elapsed >= min_t && reached)) begin
        finish((s_cnt == 0 || s_cnt < min_s) ? STAT_TOO_FEW : STAT_OK);
        return;
      end
      v[0] = w.axis_x;
      v[1] = w.axis_y;
      v[2] = w.axis_z;
      k = (w.action == ACT_GYRO);
      if (!seeded[k]) begin
        for (int j = 0; j < 3; j++) begin
          lo[k][j] = v[j]; hi[k][j] = v[j];
        end
        seeded[k] = 1;
        return;
      end
      if (track(k, v, k ? longint'(gyr_lim) : longint'(acc_lim))) begin
        finish(STAT_MOTION);
        return;
      end
      if (k == 0) return;
      room = s_cnt < 20'hFFFFF;
      if (room) begin
        for (int j = 0; j < 3; j++) g_tot[j] += v[j];
        s_cnt++;
      end
      if (temp_ok(w)) begin
        if (room) begin
          t_tot += t; t_cnt++;
        end
        if (!t_any) begin
          t_any = 1; t_lo = t; t_hi = t;
        end
        if (t < t_lo) t_lo = t;
        if (t > t_hi) t_hi = t;
        if (t_hi - t_lo >= int'(span_lim)) reached = 1;
      end
    endfunction

    function bit check_result(out_word_t got, output string msg);
      out_word_t e;
      if (expected_q.size() == 0) begin
        msg = $sformatf("unexpected result word %h", got);
        return 0;
      end
      e = expected_q.pop_front();
      msg = $sformatf("result mismatch: got %h expected %h", got, e);
      return got == e;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bias_scoreboard sb = new();
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cnt = 0;
  int cycles = 0;
  longint base[3];
  longint amp;

  imu_gyro_bias_collector_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[imu_gyro_bias_collector_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(in_word);
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_result(out_word, msg)) report(msg);
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < recv_idle);
  end

  function automatic in_word_t make_word(logic [2:0] act);
    in_word_t w;
    w.action = act;
    w.axis_x = $urandom;
    w.axis_y = $urandom;
    w.axis_z = $urandom;
    w.temperature = 16'($urandom);
    w.temp_present = 1'($urandom);
    return w;
  endfunction

  task automatic send(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_act(logic [2:0] act, longint x, longint y, longint z,
                          int t, bit tp);
    in_word_t w;
    w = make_word(act);
    w.axis_x = 32'(x);
    w.axis_y = 32'(y);
    w.axis_z = 32'(z);
    w.temperature = 16'(t);
    w.temp_present = tp;
    send(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    if (sb.running) send(make_word(ACT_TIMEOUT));
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(int mt, int nt, int ms, longint al, longint gl, int sl);
    drain();
    write_reg(CFG_MAX_TIME, CFG_W'(mt));
    write_reg(CFG_MIN_TIME, CFG_W'(nt));
    write_reg(CFG_MIN_SAMPLES, CFG_W'(ms));
    write_reg(CFG_ACC_LIMIT, CFG_W'(al));
    write_reg(CFG_GYR_LIMIT, CFG_W'(gl));
    write_reg(CFG_SPAN_LIMIT, CFG_W'(sl));
  endtask

  function automatic int rand_temp();
    if ($urandom_range(9) == 0) return $signed(16'($urandom));
    return $urandom_range(0, 21200) - 5200;
  endfunction

  task automatic send_sample(logic [2:0] act);
    longint a;
    a = (amp > 0) ? amp : 0;
    if ($urandom_range(29) == 0) a = 64'h7FFF_FFFF;
    send_act(act, base[0] + $urandom_range(0, a), base[1] + $urandom_range(0, a),
             base[2] + $urandom_range(0, a), rand_temp(), $urandom_range(9) != 0);
  endtask

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (!sb.running || $urandom_range(99) < 2) begin
        for (int j = 0; j < 3; j++) base[j] = $signed($urandom);
        amp = (sb.gyr_lim < sb.acc_lim ? sb.gyr_lim : sb.acc_lim) / 3;
        if ($urandom_range(3) == 0) amp = $urandom_range(0, 50);
        send_act(ACT_START, 0, 0, 0, rand_temp(), $urandom_range(9) != 0);
      end else begin
        r = $urandom_range(99);
        if (r < 45) send_sample(ACT_GYRO);
        else if (r < 63) send_sample(ACT_ACCEL);
        else if (r < 93) send(make_word(ACT_TICK));
        else if (r < 95) send(make_word(ACT_TIMEOUT));
        else if (r < 97) send(make_word(3'($urandom_range(5, 7))));
        else send(make_word(3'($urandom_range(0, 7))));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed runs
    write_all(3, 1, 2, 1000, 1000, 100);
    send_act(ACT_GYRO, 0, 0, 0, 0, 1);
    send(make_word(ACT_TICK));
    send(make_word(ACT_TIMEOUT));
    send_act(ACT_START, 0, 0, 0, 32767, 1);
    send_act(ACT_ACCEL, -64'sd2147483648, 64'sd2147483647, 0, 0, 0);
    send_act(ACT_GYRO, -64'sd2147483648, 64'sd2147483647, -5, 0, 1);
    send_act(ACT_GYRO, -64'sd2147483648, 64'sd2147483000, -9, 100, 1);
    send_act(ACT_GYRO, -64'sd2147482700, 64'sd2147483647, -1, -5119, 1);
    send_act(ACT_GYRO, -64'sd2147483000, 64'sd2147483100, 0, 15359, 1);
    send_act(ACT_GYRO, -64'sd2147483000, 64'sd2147483100, 0, -32768, 1);
    repeat (3) send(make_word(ACT_TICK));
    send_act(ACT_GYRO, 0, 0, 0, 0, 1);
    send_act(ACT_START, 0, 0, 0, -5120, 1);
    send(make_word(3'd5));
    send(make_word(3'd6));
    send(make_word(3'd7));
    send_act(ACT_ACCEL, 0, 0, 0, 0, 1);
    send_act(ACT_ACCEL, 64'sd2147483647, 0, 0, 0, 1);
    send_act(ACT_START, 0, 0, 0, 15360, 1);
    send_act(ACT_START, 0, 0, 0, 0, 0);
    repeat (3) send(make_word(ACT_TICK));
    send_act(ACT_ACCEL, 0, 0, 0, 0, 1);
    send_act(ACT_START, 0, 0, 0, 0, 1);
    send(make_word(ACT_TIMEOUT));

    // random phases over register settings and idling modes
    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: write_all($urandom_range(2, 40), $urandom_range(0, 20),
                     $urandom_range(0, 6), $urandom_range(0, 32'h7FFF_FFFF),
                     $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 3000));
        1: begin
          if (p == 1) write_all(0, 0, 0, 0, 0, 0);
          else write_all(65535, 65535, 1048575, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767);
        end
        default: write_all($urandom_range(5, 30), $urandom_range(0, 65535),
                           $urandom_range(0, 1048575), $urandom_range(0, 4000),
                           $urandom_range(0, 4000), $urandom_range(0, 32767));
      endcase
      if (p < 3) begin
        send_idle = 9; recv_idle = 77;
      end else if (p < 6) begin
        send_idle = 77; recv_idle = 9;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if (p == 6) hold_cnt = 600;
      random_items(135);
    end

    drain();
    if (errors == 0 && sb.pending() == 0) begin
      $display("[imu_gyro_bias_collector_top] OK");
    end else begin
      $display("[imu_gyro_bias_collector_top] ERROR");
    end
    $finish;
  end
endmodule
